@@ rtl/iewv_pkg.sv @@
// ----------------------------------------------------------------------------
// IMU EWMA and Welford variance package
// Shared types and constants for the per-axis averaging block.
// ----------------------------------------------------------------------------
package iewv_pkg;

	localparam int NUM_AXES  = 6;
	localparam int AXIS_BITS = 3;
	localparam int ALPHA_BITS = 17;
	// The squared-deviation product relies on 16-bit samples, so the width is fixed.
	localparam int SAMPLE_BITS = 16;
	localparam logic [16:0] ALPHA_ONE   = 17'd65536;
	localparam logic [16:0] ALPHA_RESET = 17'd6554;
	localparam logic [30:0] SPREAD_MAX  = 31'h7FFF_FFFF;

	// Request and answer of the shared divider.
	typedef struct packed {
		logic        start;
		logic [63:0] dividend;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [63:0] quotient;
	} div_rsp_t;

endpackage

@@ rtl/iewv_divider.sv @@
// ----------------------------------------------------------------------------
// IMU EWMA and Welford variance divider
// Restoring divider of a 64-bit dividend by the packet count, one bit a cycle.
// ----------------------------------------------------------------------------
module iewv_divider #(
	parameter int COUNT_BITS = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  iewv_pkg::div_req_t        req,
	input  logic [COUNT_BITS-1:0]     divisor,
	output iewv_pkg::div_rsp_t        rsp
);
	import iewv_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [6:0]        bit_q;
	logic [63:0]       quot_q;
	logic [COUNT_BITS:0] rem_q;
	logic [COUNT_BITS:0] trial;
	logic [COUNT_BITS:0] rem_shift;

	// One quotient bit per cycle, most significant first.
	always_comb begin
		rem_shift = {rem_q[COUNT_BITS-1:0], quot_q[63]};
		trial     = rem_shift - {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			bit_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				bit_q  <= 7'd0;
			end else if (busy_q) begin
				bit_q <= bit_q + 7'd1;
				if (bit_q == 7'd63) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quot_q <= req.dividend;
			rem_q  <= '0;
		end else if (busy_q) begin
			if (!trial[COUNT_BITS]) begin
				rem_q  <= trial;
				quot_q <= {quot_q[62:0], 1'b1};
			end else begin
				rem_q  <= rem_shift;
				quot_q <= {quot_q[62:0], 1'b0};
			end
		end
	end

	assign rsp = '{done: done_q, quotient: quot_q};

endmodule

@@ rtl/imu_ewma_welford_variance.sv @@
// ----------------------------------------------------------------------------
// IMU EWMA and Welford variance
// Per-axis exponential average and running population variance of six samples.
// ----------------------------------------------------------------------------
// Each axis passes in turn through one multiplier and one bit-serial divider used
// twice. A new packet is taken only after the result of the last one is accepted.
// Reset clears the averages, means, squared-deviation sums and the count, and
// loads alpha with 6554.
module imu_ewma_welford_variance #(
	parameter int COUNT_BITS  = 32
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [16:0]              cfg_wdata,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [iewv_pkg::SAMPLE_BITS-1:0] sample_accel_x,
	input  logic signed [iewv_pkg::SAMPLE_BITS-1:0] sample_accel_y,
	input  logic signed [iewv_pkg::SAMPLE_BITS-1:0] sample_accel_z,
	input  logic signed [iewv_pkg::SAMPLE_BITS-1:0] sample_gyro_x,
	input  logic signed [iewv_pkg::SAMPLE_BITS-1:0] sample_gyro_y,
	input  logic signed [iewv_pkg::SAMPLE_BITS-1:0] sample_gyro_z,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic signed [31:0]       avg_accel_x,
	output logic signed [31:0]       avg_accel_y,
	output logic signed [31:0]       avg_accel_z,
	output logic signed [31:0]       avg_gyro_x,
	output logic signed [31:0]       avg_gyro_y,
	output logic signed [31:0]       avg_gyro_z,
	output logic [30:0]              spread_accel_x,
	output logic [30:0]              spread_accel_y,
	output logic [30:0]              spread_accel_z,
	output logic [30:0]              spread_gyro_x,
	output logic [30:0]              spread_gyro_y,
	output logic [30:0]              spread_gyro_z
);
	import iewv_pkg::*;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_EWMA1 = 4'd1;
	localparam logic [3:0] ST_EWMA2 = 4'd2;
	localparam logic [3:0] ST_MDIV  = 4'd3;
	localparam logic [3:0] ST_MWAIT = 4'd4;
	localparam logic [3:0] ST_MEAN  = 4'd5;
	localparam logic [3:0] ST_SQ    = 4'd6;
	localparam logic [3:0] ST_M2    = 4'd7;
	localparam logic [3:0] ST_VWAIT = 4'd8;
	localparam logic [3:0] ST_NEXT  = 4'd9;
	localparam logic [3:0] ST_OUT   = 4'd10;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

	logic [3:0]            state_q;
	logic [AXIS_BITS-1:0]  axis_q;
	logic [16:0]           alpha_q;
	logic [COUNT_BITS-1:0] count_q;
	logic signed [SAMPLE_BITS-1:0] samp_q [NUM_AXES];
	logic signed [31:0]    avg_q  [NUM_AXES];
	logic signed [31:0]    mean_q [NUM_AXES];
	logic [63:0]           m2_q   [NUM_AXES];
	logic [30:0]           var_q  [NUM_AXES];
	logic signed [63:0]    acc_q;
	logic [63:0]           dmag_q;
	logic                  dneg_q;
	logic [63:0]           prod_q;
	logic [16:0]           a_eff;
	logic signed [SAMPLE_BITS-1:0] s_cur;
	logic signed [63:0]    big_s;
	logic signed [63:0]    delta;
	logic signed [63:0]    mean_sum;
	logic signed [31:0]    mean_new;
	logic signed [63:0]    delta2;
	logic [63:0]           d2mag;
	logic signed [63:0]    rnd;
	logic [64:0]           m2_sum;
	logic [63:0]           vq;
	div_req_t              dreq;
	div_rsp_t              drsp;

	// Shared multiplier: 32x32 magnitude product, one per cycle.
	logic [31:0]           mul_a, mul_b;
	logic [63:0]           mul_p;

	assign a_eff  = (alpha_q > ALPHA_ONE) ? ALPHA_ONE : alpha_q;
	assign s_cur  = samp_q[axis_q];
	assign big_s  = 64'(s_cur) <<< 16;
	assign delta  = big_s - 64'(mean_q[axis_q]);
	assign mean_sum = 64'(mean_q[axis_q]) +
		(dneg_q ? -$signed(drsp.quotient) : $signed(drsp.quotient));
	assign mean_new = (mean_sum > 64'sd2147483647) ? 32'sh7FFF_FFFF :
		(mean_sum < -64'sd2147483648) ? 32'sh8000_0000 : mean_sum[31:0];
	assign delta2 = big_s - 64'(mean_q[axis_q]);
	assign d2mag  = delta2[63] ? 64'(-delta2) : 64'(delta2);
	assign rnd    = (acc_q + 64'sd32768) >>> 16;
	assign m2_sum = {1'b0, m2_q[axis_q]} + {1'b0, prod_q};
	assign vq     = drsp.quotient >> 16;

	// Magnitudes stay below 2^32 because samples and means fit in 32 bits.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_EWMA1: begin
				mul_a = 32'(a_eff);
				mul_b = s_cur[SAMPLE_BITS-1] ? 32'(-32'(s_cur)) : 32'(s_cur);
			end
			ST_EWMA2: begin
				mul_a = 32'(ALPHA_ONE - a_eff);
				mul_b = avg_q[axis_q][31] ? -avg_q[axis_q] : avg_q[axis_q];
			end
			ST_SQ: begin
				mul_a = dmag_q[31:0];
				mul_b = d2mag[31:0];
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_p = 64'(mul_a) * 64'(mul_b);
	end

	assign dreq.start    = (state_q == ST_MDIV) || (state_q == ST_M2);
	assign dreq.dividend = (state_q == ST_MDIV) ? 64'(delta[63] ? -delta : delta) :
		(m2_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : m2_sum[63:0]);

	iewv_divider #(.COUNT_BITS(COUNT_BITS)) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (dreq),
		.divisor (count_q),
		.rsp     (drsp)
	);

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);

	// Sequencer and state update, one axis at a time.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			axis_q  <= '0;
			alpha_q <= ALPHA_RESET;
			count_q <= '0;
			for (int i = 0; i < NUM_AXES; i++) begin
				avg_q[i]  <= '0;
				mean_q[i] <= '0;
				m2_q[i]   <= '0;
			end
		end else begin
			if (cfg_we) begin
				alpha_q <= cfg_wdata;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						axis_q  <= '0;
						if (count_q != COUNT_MAX) begin
							count_q <= count_q + 1'b1;
						end
						state_q <= ST_EWMA1;
					end
				end
				ST_EWMA1: begin
					acc_q   <= s_cur[SAMPLE_BITS-1] ? -$signed(mul_p << 16)
						: $signed(mul_p << 16);
					state_q <= ST_EWMA2;
				end
				ST_EWMA2: begin
					state_q <= ST_MDIV;
					acc_q   <= acc_q + (avg_q[axis_q][31] ? -$signed(mul_p)
						: $signed(mul_p));
				end
				ST_MDIV: begin
					if (rnd > 64'sd2147483647) begin
						avg_q[axis_q] <= 32'sh7FFF_FFFF;
					end else if (rnd < -64'sd2147483648) begin
						avg_q[axis_q] <= 32'sh8000_0000;
					end else begin
						avg_q[axis_q] <= rnd[31:0];
					end
					dmag_q  <= delta[63] ? 64'(-delta) : 64'(delta);
					dneg_q  <= delta[63];
					state_q <= ST_MWAIT;
				end
				ST_MWAIT: begin
					if (drsp.done) begin
						mean_q[axis_q] <= mean_new;
						state_q <= ST_SQ;
					end
				end
				ST_SQ: begin
					// Both magnitudes are below 2^32, so the scaled product always fits.
					prod_q  <= 64'(mul_p[63:16]);
					state_q <= ST_M2;
				end
				ST_M2: begin
					m2_q[axis_q] <= dreq.dividend;
					state_q <= ST_VWAIT;
				end
				ST_VWAIT: begin
					if (drsp.done) begin
						if (count_q < 2) begin
							var_q[axis_q] <= '0;
						end else if (vq > 64'(SPREAD_MAX)) begin
							var_q[axis_q] <= SPREAD_MAX;
						end else begin
							var_q[axis_q] <= vq[30:0];
						end
						state_q <= ST_NEXT;
					end
				end
				ST_NEXT: begin
					if (axis_q == AXIS_BITS'(NUM_AXES - 1)) begin
						state_q <= ST_OUT;
					end else begin
						axis_q  <= axis_q + 1'b1;
						state_q <= ST_EWMA1;
					end
				end
				ST_OUT: begin
					if (out_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Sample capture at the input transfer.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			samp_q[0] <= sample_accel_x;
			samp_q[1] <= sample_accel_y;
			samp_q[2] <= sample_accel_z;
			samp_q[3] <= sample_gyro_x;
			samp_q[4] <= sample_gyro_y;
			samp_q[5] <= sample_gyro_z;
		end
	end

	assign avg_accel_x = avg_q[0];
	assign avg_accel_y = avg_q[1];
	assign avg_accel_z = avg_q[2];
	assign avg_gyro_x  = avg_q[3];
	assign avg_gyro_y  = avg_q[4];
	assign avg_gyro_z  = avg_q[5];
	assign spread_accel_x = var_q[0];
	assign spread_accel_y = var_q[1];
	assign spread_accel_z = var_q[2];
	assign spread_gyro_x  = var_q[3];
	assign spread_gyro_y  = var_q[4];
	assign spread_gyro_z  = var_q[5];

	// The block never accepts an item while a result waits.
	assert property (@(posedge clk) disable iff (!arst_n) !(in_ready && out_valid))
		else $error("input ready while result pending");

	// The divider only finishes while the sequencer waits for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		drsp.done |-> (state_q == ST_MWAIT || state_q == ST_VWAIT))
		else $error("divider finished outside a wait state");

	// An input transfer always starts on the first axis.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_EWMA1 && axis_q == '0))
		else $error("sequencer did not start at the first axis");

endmodule

@@ tb/sv/imu_ewma_welford_variance_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU feature result checker
// Watches the packet and result channels, predicts the six averages and the
// six variances of every accepted packet, and compares each result with them.
// ----------------------------------------------------------------------------
module imu_ewma_welford_variance_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [16:0]        cfg_wdata,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic signed [15:0] sample_accel_x,
	input  logic signed [15:0] sample_accel_y,
	input  logic signed [15:0] sample_accel_z,
	input  logic signed [15:0] sample_gyro_x,
	input  logic signed [15:0] sample_gyro_y,
	input  logic signed [15:0] sample_gyro_z,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic signed [31:0] avg_accel_x,
	input  logic signed [31:0] avg_accel_y,
	input  logic signed [31:0] avg_accel_z,
	input  logic signed [31:0] avg_gyro_x,
	input  logic signed [31:0] avg_gyro_y,
	input  logic signed [31:0] avg_gyro_z,
	input  logic [30:0]        spread_accel_x,
	input  logic [30:0]        spread_accel_y,
	input  logic [30:0]        spread_accel_z,
	input  logic [30:0]        spread_gyro_x,
	input  logic [30:0]        spread_gyro_y,
	input  logic [30:0]        spread_gyro_z,
	output int                 fail_count,
	output int                 pending,
	output int                 results_seen
);
	import iewv_pkg::*;

	typedef struct packed {
		logic signed [5:0][31:0] avg;
		logic [5:0][30:0]        spread;
	} features_t;

	features_t         expected_features[$];
	logic [16:0]       weight;
	logic signed [31:0] ewma[6];
	logic signed [31:0] run_mean[6];
	logic [63:0]       sq_dev[6];
	logic [31:0]       packets;

	assign pending = expected_features.size();

	function automatic logic signed [31:0] clamp32(input logic signed [65:0] v);
		if (v > 66'sd2147483647)
			return 32'sh7FFF_FFFF;
		if (v < -66'sd2147483648)
			return 32'sh8000_0000;
		return v[31:0];
	endfunction

	// Advance every axis by one packet and return the resulting features.
	function automatic features_t update_features(input logic signed [5:0][15:0] s);
		features_t f;
		logic signed [65:0] a, big_s, acc, delta, delta2, step;
		logic [65:0] mag_d, mag_d2, q;
		logic [127:0] prod, add;
		logic [64:0] sum;
		logic [63:0] v;
		a = (weight > ALPHA_ONE) ? 66'sd65536 : $signed({49'd0, weight});
		if (packets != 32'hFFFF_FFFF)
			packets = packets + 1;
		for (int i = 0; i < NUM_AXES; i++) begin
			big_s = $signed({{50{s[i][15]}}, s[i]}) * 66'sd65536;
			acc = a * big_s + (66'sd65536 - a) * ewma[i] + 66'sd32768;
			ewma[i] = clamp32(acc >>> 16);
			f.avg[i] = ewma[i];
			// Welford mean update; the division truncates toward zero.
			delta = big_s - run_mean[i];
			mag_d = delta < 0 ? -delta : delta;
			q = mag_d / {34'd0, packets};
			step = delta < 0 ? -$signed(q) : $signed(q);
			run_mean[i] = clamp32(run_mean[i] + step);
			delta2 = big_s - run_mean[i];
			mag_d2 = delta2 < 0 ? -delta2 : delta2;
			prod = {62'd0, mag_d} * {62'd0, mag_d2};
			add = prod >> 16;
			if (add[127:64] != 0)
				add = 128'hFFFF_FFFF_FFFF_FFFF;
			sum = {1'b0, sq_dev[i]} + {1'b0, add[63:0]};
			sq_dev[i] = sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : sum[63:0];
			if (packets < 2) begin
				v = 0;
			end else begin
				v = (sq_dev[i] / {32'd0, packets}) >> 16;
				if (v > {33'd0, SPREAD_MAX})
					v = {33'd0, SPREAD_MAX};
			end
			f.spread[i] = v[30:0];
		end
		return f;
	endfunction

	// Track configuration and predict on every accepted packet.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight = ALPHA_RESET;
			packets = 0;
			for (int i = 0; i < NUM_AXES; i++) begin
				ewma[i] = 0;
				run_mean[i] = 0;
				sq_dev[i] = 0;
			end
		end else begin
			if (cfg_we)
				weight = cfg_wdata;
			if (in_valid && in_ready)
				expected_features = {expected_features, update_features({sample_gyro_z,
					sample_gyro_y, sample_gyro_x, sample_accel_z, sample_accel_y,
					sample_accel_x})};
		end
	end

	// Compare each result transfer with the oldest prediction.
	initial begin
		fail_count = 0;
		results_seen = 0;
		forever begin
			features_t got, want;
			@(posedge clk);
			if (arst_n && out_valid && out_ready) begin
				got.avg = {avg_gyro_z, avg_gyro_y, avg_gyro_x,
					avg_accel_z, avg_accel_y, avg_accel_x};
				got.spread = {spread_gyro_z, spread_gyro_y, spread_gyro_x,
					spread_accel_z, spread_accel_y, spread_accel_x};
				results_seen++;
				if (expected_features.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("Unexpected result transfer at %0t", $realtime);
				end else begin
					want = expected_features.pop_front();
					for (int i = 0; i < NUM_AXES; i++) begin
						if (got.avg[i] !== want.avg[i] ||
								got.spread[i] !== want.spread[i]) begin
							fail_count++;
							if (fail_count <= 10)
								$display("Axis %0d result %0d: avg %0d/%0d spread %0d/%0d %s",
									i, results_seen, want.avg[i], got.avg[i],
									want.spread[i], got.spread[i],
									"(expected/actual)");
						end
					end
				end
			end
		end
	end

endmodule

@@ tb/sv/imu_ewma_welford_variance_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IMU EWMA and Welford variance testbench
// Drives directed and random packets under several alpha settings and idle
// patterns, and reports the verdict from the result checker.
// ----------------------------------------------------------------------------
module imu_ewma_welford_variance_test;
	import iewv_pkg::*;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [16:0] cfg_wdata = 0;
	logic in_valid = 0;
	logic in_ready;
	logic signed [15:0] sample_accel_x = 0, sample_accel_y = 0, sample_accel_z = 0;
	logic signed [15:0] sample_gyro_x = 0, sample_gyro_y = 0, sample_gyro_z = 0;
	logic out_valid;
	logic out_ready = 0;
	logic signed [31:0] avg_accel_x, avg_accel_y, avg_accel_z;
	logic signed [31:0] avg_gyro_x, avg_gyro_y, avg_gyro_z;
	logic [30:0] spread_accel_x, spread_accel_y, spread_accel_z;
	logic [30:0] spread_gyro_x, spread_gyro_y, spread_gyro_z;
	int fail_count, pending, results_seen;
	int send_idle_pct = 0, recv_stall_pct = 0;
	int packets_sent = 0;

	always #5 clk = ~clk;

	imu_ewma_welford_variance dut (.*);
	imu_ewma_welford_variance_checker checker_i (.*);

	// Result side stalls at random according to the current phase.
	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_stall_pct);

	// Present one packet, with a random gap first, and wait for its transfer.
	// Valid is left high afterwards; the next gap or the caller drops it.
	task automatic send_packet(input logic signed [5:0][15:0] s);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		{sample_gyro_z, sample_gyro_y, sample_gyro_x,
			sample_accel_z, sample_accel_y, sample_accel_x} <= s;
		do @(posedge clk); while (!in_ready);
		packets_sent++;
	endtask

	// Wait for every result, then let the block settle, then set alpha.
	task automatic set_alpha(input logic [16:0] value);
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (1000) @(posedge clk);
		cfg_we <= 1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	function automatic logic signed [5:0][15:0] random_packet();
		logic signed [5:0][15:0] s;
		int mode;
		mode = $urandom_range(9);
		for (int i = 0; i < 6; i++) begin
			if (mode == 0)
				s[i] = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
			else if (mode < 4)
				s[i] = $signed(16'($urandom_range(400))) - 16'sd200;
			else
				s[i] = 16'($urandom);
		end
		return s;
	endfunction

	initial begin
		logic [16:0] alphas[6];
		int pct_send[4], pct_recv[4];
		alphas = '{17'd0, 17'd65536, 17'd131071, 17'd1, 17'd32768, 17'd6554};
		pct_send = '{0, 77, 0, 18};
		pct_recv = '{0, 0, 77, 18};
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: extremes under the reset alpha, a single first packet with zero
		// variance, full-scale swings that stress the squared-deviation sum.
		send_packet({6{16'sh7FFF}});
		send_packet({6{16'sh8000}});
		send_packet({6{16'sh0000}});
		send_packet({16'sh7FFF, 16'sh8000, 16'sh0001, 16'shFFFF, 16'sh5555, 16'shAAAA});
		for (int k = 0; k < 8; k++)
			send_packet(k[0] ? {6{16'sh8000}} : {6{16'sh7FFF}});
		// Alpha of one, values above one which act as one, and alpha of zero.
		set_alpha(17'd65536);
		send_packet({6{16'sh1234}});
		send_packet({6{16'sh8000}});
		set_alpha(17'd131071);
		send_packet({6{16'sh7FFF}});
		send_packet({6{16'shFFFF}});
		set_alpha(17'd0);
		send_packet({6{16'sh7FFF}});
		send_packet({6{16'sh8000}});

		// Random packets across alpha settings and idle phases.
		for (int ph = 0; ph < 12; ph++) begin
			set_alpha(ph < 6 ? alphas[ph] : 17'($urandom_range(131071)));
			send_idle_pct = pct_send[ph % 4];
			recv_stall_pct = pct_recv[ph % 4];
			for (int n = 0; n < 96; n++)
				send_packet(random_packet());
		end
		in_valid <= 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (1000) @(posedge clk);
		$display("Sent %0d packets over 12 alpha settings and four idle patterns;",
			packets_sent);
		$display("checked %0d results.", results_seen);
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Guard against a hung handshake.
	initial begin
		#60ms;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/iewv_pkg.sv
rtl/iewv_divider.sv
rtl/imu_ewma_welford_variance.sv
tb/sv/imu_ewma_welford_variance_checker.sv
tb/sv/imu_ewma_welford_variance_test.sv
